@@ rtl/aeev_pkg.sv @@
// ----------------------------------------------------------------------------
// aeev_pkg
// Shared types, constants and the exp(-x) table for the auto-exposure adapter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aeev_pkg;

  // Fixed-point setup
  localparam int EV_FRAC_BITS    = 8;
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int EXP_TAB_LOG2    = $clog2(EXP_TABLE_DEPTH);

  // Constants in Q.20; all but SNAP rounded to nearest into the EV format
  localparam int Q20_LOG2_8000 = 13595610;
  localparam int Q20_KEY_LO    = 12163482;
  localparam int Q20_KEY_HI    = 17406362;
  localparam int Q20_SNAP      = 1048;

  localparam int Q20_SHIFT = 20 - EV_FRAC_BITS;
  localparam int Q20_HALF  = 1 << (Q20_SHIFT - 1);

  localparam int LOG2_8000_EV = (Q20_LOG2_8000 + Q20_HALF) >> Q20_SHIFT;
  localparam int KEY_LO_EV    = (Q20_KEY_LO + Q20_HALF) >> Q20_SHIFT;
  localparam int KEY_HI_EV    = (Q20_KEY_HI + Q20_HALF) >> Q20_SHIFT;
  // |r| << Q20_SHIFT < SNAP + 1  <=>  |r| <= SNAP >> Q20_SHIFT
  localparam int SNAP_LIM_EV  = Q20_SNAP >> Q20_SHIFT;

  // APB register map
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_EXPOSURE_COMP = 3'd0;
  localparam logic [2:0] REG_MIN_EV        = 3'd1;
  localparam logic [2:0] REG_MAX_EV        = 3'd2;
  localparam logic [2:0] REG_RATE_UP       = 3'd3;
  localparam logic [2:0] REG_RATE_DOWN     = 3'd4;
  localparam logic [2:0] REG_WARMUP        = 3'd5;

  typedef struct packed {
    logic signed [15:0] exposure_comp;
    logic signed [15:0] min_ev;
    logic signed [15:0] max_ev;
    logic        [15:0] rate_up;
    logic        [15:0] rate_down;
    logic        [3:0]  warmup_frames;
  } cfg_t;

  // Sequencer strobes into the datapath
  typedef struct packed {
    logic capture;
    logic tgt1;
    logic tgt2;
    logic load_ev;
    logic mul1;
    logic look;
    logic mul2;
    logic upd;
    logic out_wr;
  } cmd_t;

  typedef struct packed {
    logic use_item;
    logic ev_loaded;
  } status_t;

  // exp(-16*i/DEPTH) in Q1.16, entry 0 is exactly 1.0
  typedef logic [16:0] exp_tab_t [0:EXP_TABLE_DEPTH];

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] z;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] a;
    for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
      // z = i/(4*DEPTH) in Q.31; exp(-z) by series, then raised to the 64th power
      z    = (64'(i) << 31) / 64'(4 * EXP_TABLE_DEPTH);
      sum  = 64'd1 << 31;
      term = 64'd1 << 31;
      for (int n = 1; n <= 12; n++) begin
        term = ((term * z) >> 31) / 64'(n);
        if (n[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      a = sum;
      for (int k = 0; k < 6; k++) begin
        a = (a * a + (64'd1 << 30)) >> 31;
      end
      tab[i] = 17'((a + (64'd1 << 14)) >> 15);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

`default_nettype wire

@@ rtl/aeev_regs.sv @@
// ----------------------------------------------------------------------------
// aeev_regs
// APB configuration registers for the auto-exposure adapter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aeev_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [aeev_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output aeev_pkg::cfg_t                  cfg
);

  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.exposure_comp <= '0;
      cfg.min_ev        <= -16'sd768;
      cfg.max_ev        <= 16'sd4608;
      cfg.rate_up       <= 16'd768;
      cfg.rate_down     <= 16'd256;
      cfg.warmup_frames <= 4'd2;
    end else if (wr_en) begin
      unique case (reg_idx)
        aeev_pkg::REG_EXPOSURE_COMP: cfg.exposure_comp <= pwdata[15:0];
        aeev_pkg::REG_MIN_EV:        cfg.min_ev        <= pwdata[15:0];
        aeev_pkg::REG_MAX_EV:        cfg.max_ev        <= pwdata[15:0];
        aeev_pkg::REG_RATE_UP:       cfg.rate_up       <= pwdata[15:0];
        aeev_pkg::REG_RATE_DOWN:     cfg.rate_down     <= pwdata[15:0];
        aeev_pkg::REG_WARMUP:        cfg.warmup_frames <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      aeev_pkg::REG_EXPOSURE_COMP: prdata = {16'd0, cfg.exposure_comp};
      aeev_pkg::REG_MIN_EV:        prdata = {16'd0, cfg.min_ev};
      aeev_pkg::REG_MAX_EV:        prdata = {16'd0, cfg.max_ev};
      aeev_pkg::REG_RATE_UP:       prdata = {16'd0, cfg.rate_up};
      aeev_pkg::REG_RATE_DOWN:     prdata = {16'd0, cfg.rate_down};
      aeev_pkg::REG_WARMUP:        prdata = {28'd0, cfg.warmup_frames};
      default:                     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/aeev_ctrl.sv @@
// ----------------------------------------------------------------------------
// aeev_ctrl
// Sequencer: steps one frame through target, multiply and lookup phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aeev_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  output logic                   result_valid,
  input  wire logic              result_ready,
  input  wire aeev_pkg::status_t status,
  output aeev_pkg::cmd_t         cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TGT1 = 3'd1;
  localparam logic [2:0] S_TGT2 = 3'd2;
  localparam logic [2:0] S_MUL1 = 3'd3;
  localparam logic [2:0] S_LOOK = 3'd4;
  localparam logic [2:0] S_MUL2 = 3'd5;
  localparam logic [2:0] S_UPD  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_TGT1;
        end
      end
      S_TGT1: begin
        cmd.tgt1   = 1'b1;
        state_next = status.use_item ? S_TGT2 : S_DONE;
      end
      S_TGT2: begin
        cmd.tgt2   = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        // first trusted frame loads the target directly
        if (status.ev_loaded) begin
          cmd.mul1   = 1'b1;
          state_next = S_LOOK;
        end else begin
          cmd.load_ev = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_LOOK: begin
        cmd.look   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!result_valid || result_ready) begin
          cmd.out_wr = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_wr) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/aeev_dp.sv @@
// ----------------------------------------------------------------------------
// aeev_dp
// Datapath: target EV, exponential adaptation and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aeev_dp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire aeev_pkg::cfg_t     cfg,
  input  wire aeev_pkg::cmd_t     cmd,
  output aeev_pkg::status_t       status,
  input  wire logic signed [12:0] log_lum_mean,
  input  wire logic               metering_valid,
  input  wire logic [15:0]        frame_time,
  output logic signed [15:0]      exposure_ev,
  output logic                    ev_updated,
  output logic                    ev_ready
);

  localparam int TL = aeev_pkg::EXP_TAB_LOG2;

  localparam logic signed [16:0] LOG2_8000 = 17'(aeev_pkg::LOG2_8000_EV);
  localparam logic signed [16:0] KEY_LO    = 17'(aeev_pkg::KEY_LO_EV);
  localparam logic signed [16:0] KEY_HI    = 17'(aeev_pkg::KEY_HI_EV);
  localparam logic        [16:0] SNAP_LIM  = 17'(aeev_pkg::SNAP_LIM_EV);

  // architectural state
  logic signed [15:0] adapted_ev;
  logic               ev_loaded;
  logic [3:0]         frames_seen;

  // per-frame working registers
  logic signed [12:0] avg;
  logic [15:0]        dt;
  logic               use_item;
  logic signed [16:0] comp;
  logic signed [15:0] target;
  logic [31:0]        x24;
  logic               d_neg;
  logic [15:0]        mag;
  logic [16:0]        t0;
  logic               big;
  logic [32:0]        prod1;
  logic [32:0]        prod2;

  // target phase 1: key-value curve
  logic signed [16:0] m;
  logic signed [16:0] dlo;
  logic signed [16:0] dhi;
  logic signed [16:0] comp_next;

  assign m   = {{4{avg[12]}}, avg} + LOG2_8000;
  assign dlo = m - KEY_LO;
  assign dhi = m - KEY_HI;

  always_comb begin
    if (m < KEY_LO) begin
      comp_next = KEY_LO + (dlo >>> 1);
    end else if (m > KEY_HI) begin
      comp_next = KEY_HI + (dhi >>> 1);
    end else begin
      comp_next = m;
    end
  end

  // target phase 2: compensation, saturation, clamps (max applied last)
  logic signed [17:0] t_raw;
  logic signed [15:0] t_sat;
  logic signed [15:0] target_next;

  assign t_raw = {comp[16], comp} - {{2{cfg.exposure_comp[15]}}, cfg.exposure_comp};

  always_comb begin
    if (t_raw > 18'sd32767) begin
      t_sat = 16'sh7fff;
    end else if (t_raw < -18'sd32768) begin
      t_sat = 16'sh8000;
    end else begin
      t_sat = t_raw[15:0];
    end
    target_next = t_sat;
    if (target_next < cfg.min_ev) begin
      target_next = cfg.min_ev;
    end
    if (target_next > cfg.max_ev) begin
      target_next = cfg.max_ev;
    end
  end

  // mul1: dt * rate (Q8.24) and the error magnitude
  logic signed [16:0] d;
  logic [15:0]        rate;

  assign d    = {target[15], target} - {adapted_ev[15], adapted_ev};
  assign rate = (target > adapted_ev) ? cfg.rate_up : cfg.rate_down;

  // lookup: table pair and interpolation product
  logic [TL-1:0] i0;
  logic [TL:0]   i1;
  logic [15:0]   frac;
  logic [16:0]   e0;
  logic [16:0]   e1;

  assign i0   = x24[27 -: TL];
  assign i1   = {1'b0, i0} + (TL+1)'(1);
  assign frac = x24[27-TL -: 16];
  assign e0   = aeev_pkg::EXP_TAB[i0];
  assign e1   = aeev_pkg::EXP_TAB[i1];

  // mul2: gain and step product
  logic [16:0] decay;
  logic [16:0] gain;

  assign decay = big ? 17'd0 : t0 - prod1[32:16] - 17'(prod1[15]);
  assign gain  = 17'h10000 - decay;

  // update: apply ceil(|d|*g) in the direction of the target
  logic [16:0]        stepm;
  logic signed [17:0] ev_moved;
  logic signed [15:0] ev_new;
  logic signed [16:0] r;
  logic [16:0]        r_abs;
  logic [33:0]        prod2_rnd;

  assign prod2_rnd = {1'b0, prod2} + 34'd65535;
  assign stepm     = prod2_rnd[32:16];
  assign ev_moved  = d_neg ? {{2{adapted_ev[15]}}, adapted_ev} - {1'b0, stepm}
                           : {{2{adapted_ev[15]}}, adapted_ev} + {1'b0, stepm};
  assign r         = {target[15], target} - {ev_moved[15], ev_moved[15:0]};
  assign r_abs     = r[16] ? 17'(-r) : 17'(r);
  assign ev_new    = (r_abs <= SNAP_LIM) ? target : ev_moved[15:0];

  assign status.use_item  = use_item;
  assign status.ev_loaded = ev_loaded;

  always_ff @(posedge clk) begin
    if (rst) begin
      adapted_ev  <= '0;
      ev_loaded   <= 1'b0;
      frames_seen <= '0;
      use_item    <= 1'b0;
    end else begin
      if (cmd.capture) begin
        use_item <= (frames_seen >= cfg.warmup_frames) && metering_valid;
        if (frames_seen != 4'hf) begin
          frames_seen <= frames_seen + 4'd1;
        end
      end
      if (cmd.load_ev) begin
        adapted_ev <= target;
        ev_loaded  <= 1'b1;
      end else if (cmd.upd) begin
        adapted_ev <= ev_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      avg <= log_lum_mean;
      dt  <= frame_time;
    end
    if (cmd.tgt1) begin
      comp <= comp_next;
    end
    if (cmd.tgt2) begin
      target <= target_next;
    end
    if (cmd.mul1) begin
      x24   <= dt * rate;
      d_neg <= d[16];
      mag   <= d[16] ? 16'(-d) : d[15:0];
    end
    if (cmd.look) begin
      t0    <= e0;
      big   <= |x24[31:28];
      prod1 <= (e0 - e1) * frac;
    end
    if (cmd.mul2) begin
      prod2 <= mag * gain;
    end
    if (cmd.out_wr) begin
      exposure_ev <= adapted_ev;
      ev_updated  <= use_item;
      ev_ready    <= ev_loaded;
    end
  end

endmodule

`default_nettype wire

@@ rtl/auto_exposure_ev_adapter_top.sv @@
// ----------------------------------------------------------------------------
// auto_exposure_ev_adapter_top
// Per-frame auto-exposure EV adaptation with APB configuration.
// ----------------------------------------------------------------------------
// One metered frame goes in per transaction and one result comes out for it.
// A frame skipped for warmup or invalid metering stops after the first target
// state, the first trusted frame (direct load) after the target calculation,
// and an adapting frame runs the whole sequence; the sequencer walks the
// target calculation, the dt*rate multiply, the exp table interpolation and
// the gain multiply one register stage at a time. A finished result sits in
// an output register, so the next frame is taken while it waits. The exp
// table is constant logic and needs no fill after reset. Write the
// configuration registers only while no frame is in flight.
`timescale 1ns / 1ps
`default_nettype none

module auto_exposure_ev_adapter_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [aeev_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  input  wire logic                        item_valid,
  output logic                             item_ready,
  input  wire logic signed [12:0]          log_lum_mean,
  input  wire logic                        metering_valid,
  input  wire logic [15:0]                 frame_time,
  output logic                             result_valid,
  input  wire logic                        result_ready,
  output logic signed [15:0]               exposure_ev,
  output logic                             ev_updated,
  output logic                             ev_ready
);

  aeev_pkg::cfg_t    cfg;
  aeev_pkg::cmd_t    cmd;
  aeev_pkg::status_t status;

  aeev_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  aeev_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd)
  );

  aeev_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .status         (status),
    .log_lum_mean   (log_lum_mean),
    .metering_valid (metering_valid),
    .frame_time     (frame_time),
    .exposure_ev    (exposure_ev),
    .ev_updated     (ev_updated),
    .ev_ready       (ev_ready)
  );

endmodule

`default_nettype wire

@@ rtl/aeev_checker.sv @@
// ----------------------------------------------------------------------------
// aeev_checker
// Port-level checks for the auto-exposure adapter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aeev_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               item_valid,
  input wire logic               item_ready,
  input wire logic               result_valid,
  input wire logic               result_ready,
  input wire logic signed [15:0] exposure_ev,
  input wire logic               ev_updated,
  input wire logic               ev_ready,
  input wire logic               pready
);

  // a stalled result keeps its payload
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(exposure_ev) && $stable(ev_updated) && $stable(ev_ready))
    else $error("result changed while stalled");

  // an update always leaves a loaded exposure behind
  a_updated_ready: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !ev_updated || ev_ready)
    else $error("ev_updated without ev_ready");

  // one frame at a time: input side closes right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("second transaction taken while busy");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind auto_exposure_ev_adapter_top aeev_checker u_aeev_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .exposure_ev  (exposure_ev),
  .ev_updated   (ev_updated),
  .ev_ready     (ev_ready),
  .pready       (pready)
);

`default_nettype wire
